// ===== hdl/lpe_pkg.sv =====
package lpe_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned ADDR_W     = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned FQ_W       = 12;
  localparam int unsigned DEG_W      = 6;
  localparam int unsigned PROD_W     = 2 * FQ_W;

  localparam logic [FQ_W-1:0] FIELD_Q = FQ_W'(3329);
  localparam logic [FQ_W-1:0] INV_EXP = FQ_W'(3329 - 2);
  localparam int unsigned     EXP_W   = FQ_W;
  localparam int unsigned     EIDX_W  = $clog2(EXP_W);

  localparam int unsigned     BARRETT_SHIFT = 36;
  localparam int unsigned     BARRETT_W     = 25;
  localparam logic [BARRETT_W-1:0] BARRETT_M = BARRETT_W'((64'd1 << BARRETT_SHIFT) / 3329);

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [FQ_W-1:0] x_value;
    logic [FQ_W-1:0] y_value;
    logic            last_query;
  } in_item_t;

  typedef struct packed {
    logic [FQ_W-1:0] value;
    logic            repeated_abscissa;
    logic            last;
  } out_item_t;

  typedef struct packed {
    logic [FQ_W-1:0] x;
    logic [FQ_W-1:0] y;
  } point_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_J_READ,
    ST_J_DATA,
    ST_K_READ,
    ST_K_DATA,
    ST_K_WAIT,
    ST_INV_LOAD,
    ST_INV_STEP,
    ST_INV_WAIT,
    ST_T1,
    ST_T1_WAIT,
    ST_T2,
    ST_T2_WAIT,
    ST_OUT
  } state_t;

  function automatic logic [FQ_W-1:0] fq_reduce(input logic [FQ_W-1:0] v);
    fq_reduce = (v >= FIELD_Q) ? FQ_W'(v - FIELD_Q) : v;
  endfunction

  function automatic logic [FQ_W-1:0] fq_sub(input logic [FQ_W-1:0] a,
                                             input logic [FQ_W-1:0] b);
    logic [FQ_W:0] t;
    t = {1'b0, a} + {1'b0, FIELD_Q} - {1'b0, b};
    fq_sub = (t >= {1'b0, FIELD_Q}) ? FQ_W'(t - {1'b0, FIELD_Q}) : t[FQ_W-1:0];
  endfunction

  function automatic logic [FQ_W-1:0] fq_add(input logic [FQ_W-1:0] a,
                                             input logic [FQ_W-1:0] b);
    logic [FQ_W:0] t;
    t = {1'b0, a} + {1'b0, b};
    fq_add = (t >= {1'b0, FIELD_Q}) ? FQ_W'(t - {1'b0, FIELD_Q}) : t[FQ_W-1:0];
  endfunction

endpackage

// ===== hdl/lpe_ram.sv =====
module lpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lpe_modmul.sv =====
module lpe_modmul (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [lpe_pkg::FQ_W-1:0] a,
  input  logic [lpe_pkg::FQ_W-1:0] b,
  output logic                     done,
  output logic [lpe_pkg::FQ_W-1:0] res
);
  import lpe_pkg::*;

  localparam int unsigned WIDE_W = PROD_W + BARRETT_W;

  logic [2:0]          vld_r;
  logic [PROD_W-1:0]   p1_r;
  logic [PROD_W-1:0]   p2_r;
  logic [FQ_W:0]       q_r;
  logic [FQ_W-1:0]     res_r;
  logic [WIDE_W-1:0]   wide;
  logic [PROD_W-1:0]   rem;
  logic [FQ_W-1:0]     res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start};
    end
  end

  assign wide = WIDE_W'(p1_r) * WIDE_W'(BARRETT_M);

  always_comb begin
    rem     = p2_r - PROD_W'(q_r) * PROD_W'(FIELD_Q);
    res_nxt = (rem >= PROD_W'(FIELD_Q)) ? FQ_W'(rem - PROD_W'(FIELD_Q)) : rem[FQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    p1_r  <= PROD_W'(a) * PROD_W'(b);
    p2_r  <= p1_r;
    q_r   <= wide[BARRETT_SHIFT +: FQ_W+1];
    res_r <= res_nxt;
  end

  assign done = vld_r[2];
  assign res  = res_r;

endmodule

// ===== hdl/lagrange_point_eval_mod_q.sv =====
// Lagrange evaluation over GF(3329). A load transaction (kind 0) stores one
// point in the cycle it is taken and leaves busy low. A query transaction (kind 1)
// holds busy high while the sequencer walks every point pair through the
// point memory and two pipelined modular multipliers, then shows the result
// for one cycle on out_strobe; the receiver must take it then, it cannot
// stall. With N = degree + 1 points, each point pair costs a memory read plus a
// pass through the multiplier pipeline, and each point takes twelve
// square-and-multiply steps for the Fermat inverse.
module lagrange_point_eval_mod_q (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [lpe_pkg::DEG_W-1:0] cfg_wdata,
  input  logic                      start,
  output logic                      busy,
  input  lpe_pkg::in_item_t         in_item,
  output logic                      out_strobe,
  output lpe_pkg::out_item_t        out_item
);
  import lpe_pkg::*;

  state_t              state_r, state_nxt;
  logic [DEG_W-1:0]    degree_r;
  logic [CNT_W-1:0]    load_idx_r;
  logic [ADDR_W-1:0]   j_r, k_r;
  logic [EIDX_W-1:0]   eidx_r;
  logic [FQ_W-1:0]     e_r, xj_r, yj_r, num_r, den_r, acc_r, base_r, term_r, sum_r;
  logic                rep_r, last_r;

  logic [CNT_W-1:0]    n_pts, deg_plus;
  logic [ADDR_W-1:0]   slot;
  logic [CNT_W-1:0]    slot_inc;
  logic                accept, do_load, do_query;
  logic                j_last, k_last;
  logic [ADDR_W-1:0]   raddr;
  point_t              rd_pt, wr_pt;
  logic                ma_start, mb_start, ma_done, mb_done;
  logic [FQ_W-1:0]     ma_a, ma_b, mb_a, mb_b, ma_res, mb_res;

  assign deg_plus = CNT_W'(degree_r) + CNT_W'(1);
  assign n_pts    = (deg_plus > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : deg_plus;
  assign slot     = (load_idx_r < n_pts) ? load_idx_r[ADDR_W-1:0] : '0;
  assign slot_inc = CNT_W'(slot) + CNT_W'(1);

  assign accept   = start && (state_r == ST_IDLE);
  assign do_load  = accept && (in_item.kind == KIND_LOAD);
  assign do_query = accept && (in_item.kind == KIND_QUERY);
  assign j_last   = (CNT_W'(j_r) == n_pts - CNT_W'(1));
  assign k_last   = (CNT_W'(k_r) == n_pts - CNT_W'(1));

  assign wr_pt.x = fq_reduce(in_item.x_value);
  assign wr_pt.y = fq_reduce(in_item.y_value);

  lpe_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (do_load),
    .waddr (slot),
    .wdata (wr_pt),
    .raddr (raddr),
    .rdata (rd_pt)
  );

  lpe_modmul u_mul_a (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ma_start),
    .a     (ma_a),
    .b     (ma_b),
    .done  (ma_done),
    .res   (ma_res)
  );

  lpe_modmul u_mul_b (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mb_start),
    .a     (mb_a),
    .b     (mb_b),
    .done  (mb_done),
    .res   (mb_res)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (do_query) state_nxt = ST_J_READ;
      ST_J_READ:   state_nxt = ST_J_DATA;
      ST_J_DATA:   state_nxt = ST_K_READ;
      ST_K_READ:   state_nxt = ST_K_DATA;
      ST_K_DATA: begin
        if (k_r != j_r) state_nxt = ST_K_WAIT;
        else if (k_last) state_nxt = ST_INV_LOAD;
        else state_nxt = ST_K_READ;
      end
      ST_K_WAIT: begin
        if (ma_done && mb_done) state_nxt = k_last ? ST_INV_LOAD : ST_K_READ;
      end
      ST_INV_LOAD: state_nxt = ST_INV_STEP;
      ST_INV_STEP: state_nxt = ST_INV_WAIT;
      ST_INV_WAIT: begin
        if (ma_done && mb_done) begin
          state_nxt = (eidx_r == EIDX_W'(EXP_W - 1)) ? ST_T1 : ST_INV_STEP;
        end
      end
      ST_T1:       state_nxt = ST_T1_WAIT;
      ST_T1_WAIT:  if (ma_done) state_nxt = ST_T2;
      ST_T2:       state_nxt = ST_T2_WAIT;
      ST_T2_WAIT: begin
        if (ma_done) state_nxt = j_last ? ST_OUT : ST_J_READ;
      end
      ST_OUT:      state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    raddr    = k_r;
    ma_start = 1'b0;
    mb_start = 1'b0;
    ma_a     = num_r;
    ma_b     = fq_sub(e_r, rd_pt.x);
    mb_a     = den_r;
    mb_b     = fq_sub(xj_r, rd_pt.x);
    case (state_r)
      ST_J_READ: raddr = j_r;
      ST_K_DATA: begin
        ma_start = (k_r != j_r);
        mb_start = (k_r != j_r);
      end
      ST_INV_STEP: begin
        ma_start = 1'b1;
        mb_start = 1'b1;
        ma_a     = acc_r;
        ma_b     = base_r;
        mb_a     = base_r;
        mb_b     = base_r;
      end
      ST_T1: begin
        ma_start = 1'b1;
        ma_a     = num_r;
        ma_b     = acc_r;
      end
      ST_T2: begin
        ma_start = 1'b1;
        ma_a     = yj_r;
        ma_b     = term_r;
      end
      default: raddr = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      degree_r   <= '0;
      load_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        degree_r <= cfg_wdata;
      end
      if (do_load) begin
        load_idx_r <= (slot_inc >= n_pts) ? '0 : slot_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        e_r    <= fq_reduce(in_item.x_value);
        last_r <= in_item.last_query;
        j_r    <= '0;
        sum_r  <= '0;
        rep_r  <= 1'b0;
      end
      ST_J_DATA: begin
        xj_r  <= rd_pt.x;
        yj_r  <= rd_pt.y;
        num_r <= FQ_W'(1);
        den_r <= FQ_W'(1);
        k_r   <= '0;
      end
      ST_K_DATA: begin
        if (k_r > j_r && rd_pt.x == xj_r) begin
          rep_r <= 1'b1;
        end
        if (k_r == j_r && !k_last) begin
          k_r <= k_r + ADDR_W'(1);
        end
      end
      ST_K_WAIT: begin
        if (ma_done) begin
          num_r <= ma_res;
          den_r <= mb_res;
          if (!k_last) begin
            k_r <= k_r + ADDR_W'(1);
          end
        end
      end
      ST_INV_LOAD: begin
        base_r <= den_r;
        acc_r  <= FQ_W'(1);
        eidx_r <= '0;
      end
      ST_INV_WAIT: begin
        if (ma_done) begin
          if (INV_EXP[eidx_r]) begin
            acc_r <= ma_res;
          end
          base_r <= mb_res;
          eidx_r <= eidx_r + EIDX_W'(1);
        end
      end
      ST_T1_WAIT: begin
        if (ma_done) begin
          term_r <= ma_res;
        end
      end
      ST_T2_WAIT: begin
        if (ma_done) begin
          sum_r <= fq_add(sum_r, ma_res);
          j_r   <= j_r + ADDR_W'(1);
        end
      end
      default: begin
        sum_r <= sum_r;
      end
    endcase
  end

  assign busy                       = (state_r != ST_IDLE);
  assign out_strobe                 = (state_r == ST_OUT);
  assign out_item.value             = sum_r;
  assign out_item.repeated_abscissa = rep_r;
  assign out_item.last              = last_r;

endmodule

// ===== hdl/lpe_checker.sv =====
module lpe_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input lpe_pkg::in_item_t         in_item,
  input logic                      out_strobe,
  input lpe_pkg::out_item_t        out_item
);
  import lpe_pkg::*;

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result shown while idle");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy) else $error("result not single cycle");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_LOAD) |=> !busy && !out_strobe)
    else $error("load transaction stalled or produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == KIND_QUERY) |=> busy)
    else $error("query transaction not started");

  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.value < FIELD_Q)) else $error("value not reduced");

endmodule

bind lagrange_point_eval_mod_q lpe_checker u_lpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
